// ===== rtl/uart_rb_pkg.sv =====
package uart_rb_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int FILL_W     = 5;
   localparam int MODE_W     = 3;

   localparam logic [MODE_W-1:0] MODE_PUT      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TX_DONE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RX_BYTE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GET      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH_TX = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FLUSH_RX = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [7:0]        data_byte;
      logic              tx_reg_empty;
   } req_type;

   typedef struct packed {
      logic              send_valid;
      logic [7:0]        send_byte;
      logic              read_valid;
      logic [7:0]        read_byte;
      logic              dropped;
      logic [FILL_W-1:0] tx_fill;
      logic [FILL_W-1:0] rx_fill;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       flush;
      logic [7:0] wr_data;
   } fifo_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       head;
   } fifo_stat_type;

endpackage

// ===== rtl/uart_rb_req_if.sv =====
interface uart_rb_req_if;
   import uart_rb_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [7:0]        data_byte;
   logic              tx_reg_empty;

   modport source (output valid, output mode, output data_byte, output tx_reg_empty,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input tx_reg_empty,
                   output ready);
endinterface

// ===== rtl/uart_rb_rsp_if.sv =====
interface uart_rb_rsp_if;
   import uart_rb_pkg::*;

   logic              valid;
   logic              ready;
   logic              send_valid;
   logic [7:0]        send_byte;
   logic              read_valid;
   logic [7:0]        read_byte;
   logic              dropped;
   logic [FILL_W-1:0] tx_fill;
   logic [FILL_W-1:0] rx_fill;

   modport source (output valid, output send_valid, output send_byte, output read_valid,
                   output read_byte, output dropped, output tx_fill, output rx_fill,
                   input ready);
   modport sink   (input valid, input send_valid, input send_byte, input read_valid,
                   input read_byte, input dropped, input tx_fill, input rx_fill,
                   output ready);
endinterface

// ===== rtl/uart_rb_fifo.sv =====
module uart_rb_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  uart_rb_pkg::fifo_cmd_type    cmd,
   output uart_rb_pkg::fifo_stat_type   stat
);
   import uart_rb_pkg::*;

   logic [7:0]       store_ff [FIFO_DEPTH];
   logic [7:0]       head_ff;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos);
      if (pos == PTR_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return pos + PTR_W'(1);
   endfunction

   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      count_in  = count_ff;
      if (cmd.flush) begin
         wr_pos_in = '0;
         rd_pos_in = '0;
         count_in  = '0;
      end else if (cmd.push) begin
         wr_pos_in = advance(wr_pos_ff);
         count_in  = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         rd_pos_in = advance(rd_pos_ff);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         count_ff  <= count_in;
      end
   end

   // head read runs every cycle; the caller never issues ops in back-to-back cycles
   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.flush) begin
         store_ff[wr_pos_ff] <= cmd.wr_data;
      end
      head_ff <= store_ff[rd_pos_ff];
   end

   assign stat.count = count_ff;
   assign stat.head  = head_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fifo count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_pos_ff == wr_pos_ff))
      else $error("empty fifo with pointers apart");

   a_op_gap: assert property (@(posedge clock) disable iff (reset)
      (cmd.push || cmd.pop || cmd.flush) |=> !(cmd.push || cmd.pop || cmd.flush))
      else $error("fifo ops in back-to-back cycles, head read is stale");

endmodule

// ===== rtl/uart_rb_ctrl.sv =====
module uart_rb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         exec,
   input  uart_rb_pkg::req_type         req,
   input  uart_rb_pkg::fifo_stat_type   tx_stat,
   input  uart_rb_pkg::fifo_stat_type   rx_stat,
   output uart_rb_pkg::fifo_cmd_type    tx_cmd,
   output uart_rb_pkg::fifo_cmd_type    rx_cmd,
   output uart_rb_pkg::rsp_type         rsp
);
   import uart_rb_pkg::*;

   logic             tx_empty, tx_full, rx_empty, rx_full;
   logic [CNT_W-1:0] tx_cnt_next, rx_cnt_next;

   assign tx_empty = (tx_stat.count == '0);
   assign tx_full  = (tx_stat.count == CNT_W'(FIFO_DEPTH));
   assign rx_empty = (rx_stat.count == '0);
   assign rx_full  = (rx_stat.count == CNT_W'(FIFO_DEPTH));

   always_comb begin
      tx_cmd = '{push: 1'b0, pop: 1'b0, flush: 1'b0, wr_data: req.data_byte};
      rx_cmd = '{push: 1'b0, pop: 1'b0, flush: 1'b0, wr_data: req.data_byte};
      rsp    = '0;
      case (req.mode)
         MODE_PUT: begin
            if (req.tx_reg_empty && tx_empty) begin
               rsp.send_valid = 1'b1;
               rsp.send_byte  = req.data_byte;
            end else if (!tx_full) begin
               tx_cmd.push = exec;
            end else begin
               rsp.dropped = 1'b1;
            end
         end
         MODE_TX_DONE: begin
            if (!tx_empty) begin
               rsp.send_valid = 1'b1;
               rsp.send_byte  = tx_stat.head;
               tx_cmd.pop     = exec;
            end
         end
         MODE_RX_BYTE: begin
            if (!rx_full) begin
               rx_cmd.push = exec;
            end else begin
               rsp.dropped = 1'b1;
            end
         end
         MODE_GET: begin
            if (!rx_empty) begin
               rsp.read_valid = 1'b1;
               rsp.read_byte  = rx_stat.head;
               rx_cmd.pop     = exec;
            end
         end
         MODE_FLUSH_TX: tx_cmd.flush = exec;
         MODE_FLUSH_RX: rx_cmd.flush = exec;
         default: ;
      endcase

      // fill after this beat
      tx_cnt_next = tx_stat.count;
      rx_cnt_next = rx_stat.count;
      case (req.mode)
         MODE_PUT:      if (!(req.tx_reg_empty && tx_empty) && !tx_full)
                           tx_cnt_next = tx_stat.count + CNT_W'(1);
         MODE_TX_DONE:  if (!tx_empty) tx_cnt_next = tx_stat.count - CNT_W'(1);
         MODE_RX_BYTE:  if (!rx_full) rx_cnt_next = rx_stat.count + CNT_W'(1);
         MODE_GET:      if (!rx_empty) rx_cnt_next = rx_stat.count - CNT_W'(1);
         MODE_FLUSH_TX: tx_cnt_next = '0;
         MODE_FLUSH_RX: rx_cnt_next = '0;
         default: ;
      endcase
      rsp.tx_fill = FILL_W'(tx_cnt_next);
      rsp.rx_fill = FILL_W'(rx_cnt_next);
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      exec |-> !(rsp.send_valid && rsp.read_valid))
      else $error("send and read in one beat");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (exec && rsp.dropped) |-> (tx_full || rx_full))
      else $error("drop without a full fifo");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      $countones({tx_cmd.push, tx_cmd.pop, tx_cmd.flush,
                  rx_cmd.push, rx_cmd.pop, rx_cmd.flush}) <= 1)
      else $error("more than one fifo op per beat");

endmodule

// ===== rtl/uart_tx_rx_ring_buffers_unit.sv =====
// channel | dir | handshake              | payload
// req_if  | in  | req_if.valid/ready      | mode, data_byte, tx_reg_empty
// rsp_if  | out | rsp_if.valid/ready      | send/read flags and bytes, dropped, fills
//
// Each request is accepted, then executed against the FIFO state.
// Each FIFO head is read from its RAM into a register, so ops never come in back-to-back cycles.
// Execute waits while the response register is still full and not taken.
// A new request is accepted while a response is waiting.
// Synchronous reset empties both FIFOs; RAM contents are not cleared.
module uart_tx_rx_ring_buffers_unit (
   input  logic          clock,
   input  logic          reset,
   uart_rb_req_if.sink   req_if,
   uart_rb_rsp_if.source rsp_if
);
   import uart_rb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic          state_ff, state_in;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_calc;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, exec;
   fifo_cmd_type  tx_cmd, rx_cmd;
   fifo_stat_type tx_stat, rx_stat;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign exec         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (exec) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{mode: req_if.mode, data_byte: req_if.data_byte,
                     tx_reg_empty: req_if.tx_reg_empty};
      end
      if (exec) begin
         rsp_ff <= rsp_calc;
      end
   end

   uart_rb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .exec    (exec),
      .req     (req_ff),
      .tx_stat (tx_stat),
      .rx_stat (rx_stat),
      .tx_cmd  (tx_cmd),
      .rx_cmd  (rx_cmd),
      .rsp     (rsp_calc)
   );

   uart_rb_fifo u_tx_fifo (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .stat  (tx_stat)
   );

   uart_rb_fifo u_rx_fifo (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .stat  (rx_stat)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.send_valid = rsp_ff.send_valid;
   assign rsp_if.send_byte  = rsp_ff.send_byte;
   assign rsp_if.read_valid = rsp_ff.read_valid;
   assign rsp_if.read_byte  = rsp_ff.read_byte;
   assign rsp_if.dropped    = rsp_ff.dropped;
   assign rsp_if.tx_fill    = rsp_ff.tx_fill;
   assign rsp_if.rx_fill    = rsp_ff.rx_fill;

   a_exec_after_idle: assert property (@(posedge clock) disable iff (reset)
      exec |=> (state_ff == ST_IDLE))
      else $error("execute did not return to idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> $stable(rsp_ff))
      else $error("waiting response overwritten");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted beat not executed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import uart_rb_pkg::*;

   localparam int TOTAL_ITEMS   = 1050;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 600000;

   // mode codes the block leaves unused
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      req_type req;
      bit      wait_drain;   // hold off until every result is back
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic [MODE_W-1:0] req_mode         = '0;
   logic [7:0]        req_data_byte    = '0;
   logic              req_tx_reg_empty = 1'b0;
   logic              rsp_ready        = 1'b0;

   uart_rb_req_if req_if ();
   uart_rb_rsp_if rsp_if ();

   assign req_if.valid        = req_valid;
   assign req_if.mode         = req_mode;
   assign req_if.data_byte    = req_data_byte;
   assign req_if.tx_reg_empty = req_tx_reg_empty;
   assign rsp_if.ready        = rsp_ready;

   uart_tx_rx_ring_buffers_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #4 clock = ~clock;

   // ring buffer state as the block should hold it
   logic [7:0]       tx_ring [FIFO_DEPTH];
   logic [PTR_W-1:0] tx_wr  = '0;
   logic [PTR_W-1:0] tx_rd  = '0;
   logic [CNT_W-1:0] tx_cnt = '0;
   logic [7:0]       rx_ring [FIFO_DEPTH];
   logic [PTR_W-1:0] rx_wr  = '0;
   logic [PTR_W-1:0] rx_rd  = '0;
   logic [CNT_W-1:0] rx_cnt = '0;

   stim_type stim_queue [$];
   rsp_type  expected_rsp [$];
   stim_type next_stim;

   logic req_taken   = 1'b0;
   int   send_gap    = 0;
   int   send_calm   = 0;
   int   stall_left  = 0;
   int   stall_calm  = 0;
   int   mismatches  = 0;
   int   cycle_count = 0;

   function automatic logic [PTR_W-1:0] next_pos(logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic rsp_type ring_step(req_type r);
      rsp_type o;
      o = '0;
      case (r.mode)
         MODE_PUT: begin
            if (r.tx_reg_empty && tx_cnt == '0) begin
               o.send_valid = 1'b1;
               o.send_byte  = r.data_byte;
            end else if (tx_cnt < CNT_W'(FIFO_DEPTH)) begin
               tx_ring[tx_wr] = r.data_byte;
               tx_wr  = next_pos(tx_wr);
               tx_cnt = tx_cnt + 1'b1;
            end else begin
               o.dropped = 1'b1;
            end
         end
         MODE_TX_DONE: begin
            if (tx_cnt != '0) begin
               o.send_valid = 1'b1;
               o.send_byte  = tx_ring[tx_rd];
               tx_rd  = next_pos(tx_rd);
               tx_cnt = tx_cnt - 1'b1;
            end
         end
         MODE_RX_BYTE: begin
            if (rx_cnt < CNT_W'(FIFO_DEPTH)) begin
               rx_ring[rx_wr] = r.data_byte;
               rx_wr  = next_pos(rx_wr);
               rx_cnt = rx_cnt + 1'b1;
            end else begin
               o.dropped = 1'b1;
            end
         end
         MODE_GET: begin
            if (rx_cnt != '0) begin
               o.read_valid = 1'b1;
               o.read_byte  = rx_ring[rx_rd];
               rx_rd  = next_pos(rx_rd);
               rx_cnt = rx_cnt - 1'b1;
            end
         end
         MODE_FLUSH_TX: begin
            tx_wr  = '0;
            tx_rd  = '0;
            tx_cnt = '0;
         end
         MODE_FLUSH_RX: begin
            rx_wr  = '0;
            rx_rd  = '0;
            rx_cnt = '0;
         end
         default: ;
      endcase
      o.tx_fill = FILL_W'(tx_cnt);
      o.rx_fill = FILL_W'(rx_cnt);
      return o;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_item(logic [MODE_W-1:0] m, logic [7:0] d, logic e, bit drain = 1'b0);
      stim_type s;
      s.req.mode         = m;
      s.req.data_byte    = d;
      s.req.tx_reg_empty = e;
      s.wait_drain       = drain;
      stim_queue.push_back(s);
   endtask

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
         mismatches++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // beat still waiting for ready
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (stim_queue.size() != 0 &&
                   !(stim_queue[0].wait_drain && expected_rsp.size() != 0)) begin
         next_stim = stim_queue.pop_front();
         req_valid        <= 1'b1;
         req_mode         <= next_stim.req.mode;
         req_data_byte    <= next_stim.req.data_byte;
         req_tx_reg_empty <= next_stim.req.tx_reg_empty;
         send_gap         <= pick_gap(send_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result backpressure
   always @(negedge clock) begin
      int g;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         g = pick_gap(stall_calm);
         rsp_ready  <= (g == 0);
         stall_left <= (g > 0) ? g - 1 : 0;
      end
   end

   // monitor: check result beats, then predict for the accepted request beat
   always @(posedge clock) begin
      rsp_type got, exp;
      req_type r;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_if.valid && rsp_ready) begin
            got.send_valid = rsp_if.send_valid;
            got.send_byte  = rsp_if.send_byte;
            got.read_valid = rsp_if.read_valid;
            got.read_byte  = rsp_if.read_byte;
            got.dropped    = rsp_if.dropped;
            got.tx_fill    = rsp_if.tx_fill;
            got.rx_fill    = rsp_if.rx_fill;
            if (expected_rsp.size() == 0) begin
               $display("%0t: result beat with none expected, actual %p", $time, got);
               mismatches++;
            end else begin
               exp = expected_rsp.pop_front();
               check_field("send_valid", 32'(exp.send_valid), 32'(got.send_valid));
               check_field("send_byte", 32'(exp.send_byte), 32'(got.send_byte));
               check_field("read_valid", 32'(exp.read_valid), 32'(got.read_valid));
               check_field("read_byte", 32'(exp.read_byte), 32'(got.read_byte));
               check_field("dropped", 32'(exp.dropped), 32'(got.dropped));
               check_field("tx_fill", 32'(exp.tx_fill), 32'(got.tx_fill));
               check_field("rx_fill", 32'(exp.rx_fill), 32'(got.rx_fill));
            end
         end
         req_taken <= req_valid && req_if.ready;
         if (req_valid && req_if.ready) begin
            r.mode         = req_mode;
            r.data_byte    = req_data_byte;
            r.tx_reg_empty = req_tx_reg_empty;
            expected_rsp.push_back(ring_step(r));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("uart_tx_rx_ring_buffers_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int pick;
      int n;
      bit drain;

      // directed: empty-FIFO cases, unused modes, direct send vs queueing, flushes
      add_item(MODE_GET, 8'h00, 1'b0);
      add_item(MODE_TX_DONE, 8'h00, 1'b1);
      add_item(MODE_SPARE_6, 8'hFF, 1'b1);
      add_item(MODE_SPARE_7, 8'h55, 1'b0);
      add_item(MODE_PUT, 8'hFF, 1'b1);
      add_item(MODE_PUT, 8'h00, 1'b0);
      add_item(MODE_PUT, 8'hA5, 1'b1);
      add_item(MODE_TX_DONE, 8'h00, 1'b0);
      add_item(MODE_TX_DONE, 8'h00, 1'b0);
      add_item(MODE_RX_BYTE, 8'h00, 1'b0);
      add_item(MODE_RX_BYTE, 8'hFF, 1'b1);
      add_item(MODE_GET, 8'h00, 1'b0);
      add_item(MODE_GET, 8'h00, 1'b0);
      add_item(MODE_GET, 8'h00, 1'b0);
      add_item(MODE_PUT, 8'h3C, 1'b0);
      add_item(MODE_FLUSH_TX, 8'h00, 1'b0);
      add_item(MODE_TX_DONE, 8'h00, 1'b1);
      add_item(MODE_RX_BYTE, 8'h5A, 1'b0);
      add_item(MODE_FLUSH_RX, 8'h00, 1'b0);
      add_item(MODE_GET, 8'h00, 1'b0);
      add_item(MODE_PUT, 8'h81, 1'b1, 1'b1);

      // random: fill/drain bursts so both FIFOs hit full and wrap, plus noise
      while (stim_queue.size() < TOTAL_ITEMS) begin
         pick  = $urandom_range(0, 99);
         drain = ($urandom_range(0, 39) == 0);
         if (pick < 35) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               add_item(MODE_PUT, 8'($urandom), ($urandom_range(0, 3) == 0), drain && i == 0);
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               add_item(MODE_TX_DONE, 8'($urandom), 1'($urandom));
         end else if (pick < 65) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               add_item(MODE_RX_BYTE, 8'($urandom), 1'($urandom), drain && i == 0);
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               add_item(MODE_GET, 8'($urandom), 1'($urandom));
         end else if (pick < 92) begin
            add_item(MODE_W'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), drain);
         end else begin
            add_item(pick[0] ? MODE_FLUSH_TX : MODE_FLUSH_RX, 8'($urandom), 1'($urandom));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_queue.size() != 0) @(negedge clock);
      // let the driver's last beat settle before checking it
      @(negedge clock);
      while ((req_valid && !req_taken) || expected_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("uart_tx_rx_ring_buffers_unit: match");
      else
         $display("uart_tx_rx_ring_buffers_unit: mismatch");
      $finish;
   end

endmodule
